// ===== hdl/ita_pkg.sv =====
// Shared types, constants and the character lookup for the integer-to-ASCII formatter.
// No dependencies; every other file imports this package.
package ita_pkg;

  // Format selector codes
  localparam logic [2:0] FMT_SDEC = 3'd0;
  localparam logic [2:0] FMT_UDEC = 3'd1;
  localparam logic [2:0] FMT_HEXL = 3'd2;
  localparam logic [2:0] FMT_HEXU = 3'd3;
  localparam logic [2:0] FMT_PTR  = 3'd4;

  localparam int FUNC_W        = 3;
  localparam int VALUE_W       = 64;
  localparam int CHAR_W        = 7;
  localparam int WORD_W        = 32;
  localparam int PTR_WIDTH_DEF = 64;
  localparam int DEC_CELLS     = 10;  // decimal digits of a 32-bit word
  localparam int NIBS          = 16;  // hex digits of a 64-bit word
  localparam int POS_W         = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;

  // Control broadcast to every BCD cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  // Map one digit to its ASCII code
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {3'b000, d};
    end else begin
      digit_char = base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

// ===== hdl/ita_bcd_cell.sv =====
// One decimal digit cell of the shift-and-add-3 binary to BCD chain.
// Depends on ita_pkg for the cell control struct.
module ita_bcd_cell (
  input  logic              clk,
  input  ita_pkg::cell_ctl_t ctl,
  input  logic              shift_in,
  output logic              shift_out,
  output logic [3:0]        digit
);
  import ita_pkg::*;

  logic [3:0] adj;

  // Add three when the digit would overflow past nine after doubling
  assign adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign shift_out = adj[3];

  // Clear on load, shift in the neighbor's bit on each conversion step
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= 4'd0;
    end else if (ctl.shift) begin
      digit <= {adj[2:0], shift_in};
    end
  end

endmodule

// ===== hdl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter: decimal through a chain of BCD cells, hex from nibbles.
// Depends on ita_pkg and ita_bcd_cell.
// Decimal items first shift through the cell chain; every format then skips leading zeros,
// then emits one character per cycle while the output is not stalled. One item at a time: a new
// item is taken only once the previous one has finished and the block is back in idle.
// Reset: rst (synchronous, active high) returns to idle and drops any pending character.
module integer_to_ascii_formatter #(
  parameter int PTR_WIDTH = ita_pkg::PTR_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ita_pkg::VALUE_W-1:0]  s_tdata,   // [63:0] value
  input  logic [ita_pkg::FUNC_W-1:0]   s_tuser,   // [2:0] func
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,   // [6:0] char_code, [7] zero
  output logic                         m_tlast    // last
);
  import ita_pkg::*;

  localparam logic [VALUE_W-1:0] PTR_MASK = VALUE_W'((65'd1 << PTR_WIDTH) - 65'd1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_PFX  = 3'd3;
  localparam logic [2:0] ST_DIGS = 3'd4;

  logic [2:0]         state;
  logic [4:0]         bit_cnt;
  logic [POS_W-1:0]   pos;
  logic [1:0]         pfx_cnt;
  logic               pfx_ptr;
  logic               dec_mode;
  logic               upper;
  logic [WORD_W-1:0]  sreg;
  logic [VALUE_W-1:0] val;

  logic               accept;
  logic               out_take;
  logic               emit;
  logic [WORD_W-1:0]  word;
  logic               neg;
  cell_ctl_t          cell_ctl;
  logic               carry [DEC_CELLS];
  logic [3:0]         bcd [DEC_CELLS];
  logic [3:0]         cur_digit;
  logic [CHAR_W-1:0]  pfx_char;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_take = !m_tvalid || m_tready;
  assign emit     = out_take && (state inside {ST_PFX, ST_DIGS});

  assign word = s_tdata[WORD_W-1:0];
  assign neg  = (s_tuser == FMT_SDEC) && word[WORD_W-1];

  // Drive the cell chain: clear on accept, shift during conversion
  assign cell_ctl.clear = accept;
  assign cell_ctl.shift = (state == ST_CONV);
  assign carry[0]       = sreg[WORD_W-1];

  // Row of BCD cells, least significant digit first
  for (genvar k = 0; k < DEC_CELLS; k++) begin : g_cell
    if (k == DEC_CELLS - 1) begin : g_top
      ita_bcd_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .shift_in (carry[k]),
        .shift_out(),
        .digit    (bcd[k])
      );
    end else begin : g_mid
      ita_bcd_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .shift_in (carry[k]),
        .shift_out(carry[k+1]),
        .digit    (bcd[k])
      );
    end
  end

  // Select the digit at the current position
  always_comb begin
    if (dec_mode) begin
      cur_digit = (pos < POS_W'(DEC_CELLS)) ? bcd[pos] : 4'd0;
    end else begin
      cur_digit = val[{pos, 2'b00} +: 4];
    end
  end

  // Prefix character: minus sign, or "0x" for pointers
  always_comb begin
    if (!pfx_ptr) begin
      pfx_char = CH_MINUS;
    end else if (pfx_cnt == 2'd2) begin
      pfx_char = CH_ZERO;
    end else begin
      pfx_char = CH_X;
    end
  end

  // Sequencer: load, convert, skip leading zeros, emit prefix and digits
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            upper    <= (s_tuser == FMT_HEXU);
            pfx_ptr  <= (s_tuser == FMT_PTR);
            pfx_cnt  <= (s_tuser == FMT_PTR) ? 2'd2 : (neg ? 2'd1 : 2'd0);
            bit_cnt  <= 5'd31;
            sreg     <= neg ? -word : word;
            dec_mode <= (s_tuser == FMT_SDEC) || (s_tuser == FMT_UDEC);
            case (s_tuser)
              FMT_SDEC, FMT_UDEC: begin
                pos   <= POS_W'(DEC_CELLS - 1);
                state <= ST_CONV;
              end
              FMT_HEXL, FMT_HEXU: begin
                val   <= {{(VALUE_W-WORD_W){1'b0}}, word};
                pos   <= POS_W'(WORD_W / 4 - 1);
                state <= ST_SKIP;
              end
              FMT_PTR: begin
                val   <= s_tdata & PTR_MASK;
                pos   <= POS_W'(NIBS - 1);
                state <= ST_SKIP;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CONV: begin
          sreg    <= {sreg[WORD_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - 5'd1;
          if (bit_cnt == 5'd0) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (pos != '0 && cur_digit == 4'd0) begin
            pos <= pos - POS_W'(1);
          end else begin
            state <= (pfx_cnt != 2'd0) ? ST_PFX : ST_DIGS;
          end
        end
        ST_PFX: begin
          if (out_take) begin
            m_tdata  <= {1'b0, pfx_char};
            m_tlast  <= 1'b0;
            pfx_cnt  <= pfx_cnt - 2'd1;
            if (pfx_cnt == 2'd1) begin
              state <= ST_DIGS;
            end
          end
        end
        ST_DIGS: begin
          if (out_take) begin
            m_tdata  <= {1'b0, digit_char(cur_digit, upper)};
            m_tlast  <= (pos == '0);
            if (pos == '0) begin
              state <= ST_IDLE;
            end else begin
              pos <= pos - POS_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ita_checker.sv =====
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
// Depends on ita_pkg and integer_to_ascii_formatter.
module ita_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [ita_pkg::VALUE_W-1:0] s_tdata,
  input logic [ita_pkg::FUNC_W-1:0]  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [7:0]                  m_tdata,
  input logic                        m_tlast
);
  import ita_pkg::*;

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  // A valid format keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser <= FMT_PTR) |=> !s_tready)
    else $error("input taken again right after a valid format");

  // No new item is taken while characters still stream out unfinished
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a text");

  // Every emitted character is a digit, a hex letter, a minus or an x
  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7] &&
      ((m_tdata >= 8'h30 && m_tdata <= 8'h39) || (m_tdata >= 8'h41 && m_tdata <= 8'h46) ||
       (m_tdata >= 8'h61 && m_tdata <= 8'h66) || m_tdata == 8'h2D || m_tdata == 8'h78))
    else $error("output character out of the expected set");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);
